// File: src/palette_box_downscaler_defines.svh
// Assertion macros used by the palette box downscaler checker.
// No dependencies; assumes clk and rst_n are visible where the macros are used.
`ifndef PALETTE_BOX_DOWNSCALER_DEFINES_SVH
`define PALETTE_BOX_DOWNSCALER_DEFINES_SVH

// Clocked check, switched off while reset is applied.
`define PBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define PBD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pbd_pkg.sv
// Package for the palette box downscaler: widths, register indexes, reset values,
// state types, the divider request/response structs and the size clamp function. No dependencies.
package pbd_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int PALETTE_SIZE  = 256;

    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 9;
    localparam int SIZE_W     = 9;
    localparam int ORIGIN_W   = 12;
    localparam int COORD_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_CHAN   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_H   = 3'd5;

    localparam logic [SIZE_W-1:0] SOURCE_W_RST = 9'd64;
    localparam logic [SIZE_W-1:0] SOURCE_H_RST = 9'd64;
    localparam logic [SIZE_W-1:0] TARGET_W_RST = 9'd32;
    localparam logic [SIZE_W-1:0] TARGET_H_RST = 9'd32;
    localparam logic [SIZE_W-1:0] SIZE_MAX     = 9'd256;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } pbd_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_LOAD,
        DV_STEP
    } pbd_div_state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } pbd_div_req_t;

    typedef struct packed {
        logic                             done;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]  quotient;
    } pbd_div_rsp_t;

    // size registers: zero acts as one, anything above 256 acts as 256
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_MAX)
            r = SIZE_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: src/pbd_divider.sv
// Shared bit-serial divider: divides three channel sums by one sample count, one
// quotient bit per cycle, channel after channel. Depends on pbd_pkg.
module pbd_divider (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  pbd_pkg::pbd_div_req_t                           req,
    input  logic [pbd_pkg::NUM_CHAN-1:0][pbd_pkg::SUM_W-1:0] sums,
    output pbd_pkg::pbd_div_rsp_t                           rsp
);
    import pbd_pkg::*;

    localparam logic [1:0] CHAN_LAST = 2'(NUM_CHAN - 1);
    localparam logic [2:0] STEP_LAST = 3'(CHAN_W - 1);

    pbd_div_state_t state_reg, state_next;
    logic [1:0]                      chan_reg, chan_next;
    logic [2:0]                      step_reg, step_next;
    logic [CNT_W-1:0]                den_reg, den_next;
    logic [CNT_W-1:0]                rem_reg, rem_next;
    logic [CHAN_W-1:0]               dvd_reg, dvd_next;
    logic [CHAN_W-1:0]               quo_reg, quo_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] res_reg, res_next;
    logic                            done_reg, done_next;

    logic [CNT_W:0]   trial;
    logic             fits;
    logic [SUM_W-1:0] sum_sel;
    logic             last_step;
    logic             last_chan;

    assign last_step = (step_reg == STEP_LAST);
    assign last_chan = (chan_reg == CHAN_LAST);
    assign sum_sel   = sums[chan_reg];
    assign trial     = {rem_reg, dvd_reg[CHAN_W-1]};
    assign fits      = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                    state_next = DV_LOAD;
            end
            DV_LOAD:
                state_next = DV_STEP;
            DV_STEP:
            begin
                if (last_step)
                    state_next = last_chan ? DV_IDLE : DV_LOAD;
            end
            default:
                state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        chan_next = chan_reg;
        step_next = step_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    den_next  = req.divisor;
                    chan_next = '0;
                end
            end
            DV_LOAD:
            begin
                // the average never exceeds 255, so the top byte is already below the count
                rem_next  = CNT_W'(sum_sel[SUM_W-1:CHAN_W]);
                dvd_next  = sum_sel[CHAN_W-1:0];
                quo_next  = '0;
                step_next = '0;
            end
            DV_STEP:
            begin
                rem_next  = fits ? CNT_W'(trial - {1'b0, den_reg}) : CNT_W'(trial);
                quo_next  = {quo_reg[CHAN_W-2:0], fits};
                dvd_next  = {dvd_reg[CHAN_W-2:0], 1'b0};
                step_next = step_reg + 3'd1;
                if (last_step)
                begin
                    res_next[chan_reg] = quo_next;
                    chan_next          = chan_reg + 2'd1;
                    done_next          = last_chan;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        rsp.done     = done_reg;
        rsp.quotient = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            chan_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            chan_reg  <= chan_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

endmodule

// File: src/palette_box_downscaler.sv
// Top level of the palette box downscaler: palette and line memories, run/row
// sequencer and output register. Depends on pbd_pkg and pbd_divider.
//
// Items with mode 0 load one palette entry and leave the sequencer idle. A pixel
// that does not end a horizontal run goes through a palette read and then an
// accumulate step. A pixel that ends a run is accepted and accumulated, then the
// shared bit-serial divider works through red, green and blue in turn and raises
// its done flag, then the word is handed to the output register once that register
// is free or the output does not stall. One result word can sit in the output
// register while the next item is accepted. Palette and line memories need no
// clearing pass after reset.
module palette_box_downscaler #(
    parameter int MAX_WIDTH = pbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [7:0]                       index,
    input  logic [pbd_pkg::CHAN_W-1:0]       entry_red,
    input  logic [pbd_pkg::CHAN_W-1:0]       entry_green,
    input  logic [pbd_pkg::CHAN_W-1:0]       entry_blue,
    input  logic [pbd_pkg::CHAN_W-1:0]       entry_alpha,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pbd_pkg::COORD_W-1:0]      pix_x,
    output logic [pbd_pkg::COORD_W-1:0]      pix_y,
    output logic [pbd_pkg::CHAN_W-1:0]       red,
    output logic [pbd_pkg::CHAN_W-1:0]       green,
    output logic [pbd_pkg::CHAN_W-1:0]       blue,
    output logic [pbd_pkg::CHAN_W-1:0]       alpha,
    output logic                             frame_end
);
    import pbd_pkg::*;

    localparam int LINE_AW = $clog2(MAX_WIDTH);

    // configuration
    logic [ORIGIN_W-1:0] origin_x_reg, origin_y_reg;
    logic [SIZE_W-1:0]   src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [SIZE_W-1:0]   w, h, nw, nh;

    // memories
    logic [4*CHAN_W-1:0] palette_mem [PALETTE_SIZE];
    logic [3*CHAN_W-1:0] line_mem    [MAX_WIDTH];
    logic [4*CHAN_W-1:0] pal_rd_reg;
    logic [3*CHAN_W-1:0] line_rd_reg;

    // sequencer and run state
    pbd_state_t state_reg, state_next;
    logic [NUM_CHAN-1:0][SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]   sample_count_reg, sample_count_next;
    logic [CHAN_W-1:0]  run_alpha_reg, run_alpha_next;
    logic [SIZE_W-1:0]  source_col_reg, source_col_next;
    logic [SIZE_W-1:0]  source_row_reg, source_row_next;
    logic [SIZE_W-1:0]  h_error_reg, h_error_next;
    logic [SIZE_W-1:0]  v_error_reg, v_error_next;
    logic [SIZE_W-1:0]  out_col_reg, out_col_next;
    logic [SIZE_W-1:0]  out_row_reg, out_row_next;

    // pending result of the run being divided
    logic [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [COORD_W-1:0] pend_y_reg, pend_y_next;
    logic               pend_end_reg, pend_end_next;
    logic [LINE_AW-1:0] wr_addr_reg, wr_addr_next;
    logic               wr_ok_reg, wr_ok_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] pix_x_reg, pix_x_next;
    logic [COORD_W-1:0] pix_y_reg, pix_y_next;
    logic [CHAN_W-1:0]  red_reg, red_next;
    logic [CHAN_W-1:0]  green_reg, green_next;
    logic [CHAN_W-1:0]  blue_reg, blue_next;
    logic [CHAN_W-1:0]  alpha_reg, alpha_next;
    logic               frame_end_reg, frame_end_next;

    // control
    logic         in_fire;
    logic         slot_free;
    logic         emit_fire;
    logic         line_wr;
    logic         line_ok;
    logic         use_line;
    logic         row_end;
    logic         last_row;
    logic         run_end;
    logic [SIZE_W:0] h_sum, v_sum, h_wrap, v_wrap;
    logic [NUM_CHAN-1:0][SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0]  acc_cnt;
    logic [CHAN_W-1:0] acc_alpha;
    logic [3*CHAN_W-1:0] line_val;

    pbd_div_req_t div_req;
    pbd_div_rsp_t div_rsp;

    pbd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sums  (sum_reg),
        .rsp   (div_rsp)
    );

    assign w  = eff_size(src_w_reg);
    assign h  = eff_size(src_h_reg);
    assign nw = eff_size(tgt_w_reg);
    assign nh = eff_size(tgt_h_reg);

    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign line_ok   = (32'(out_col_reg) < 32'(MAX_WIDTH));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            src_w_reg    <= SOURCE_W_RST;
            src_h_reg    <= SOURCE_H_RST;
            tgt_w_reg    <= TARGET_W_RST;
            tgt_h_reg    <= TARGET_H_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                CFG_SOURCE_W: src_w_reg    <= cfg_data[SIZE_W-1:0];
                CFG_SOURCE_H: src_h_reg    <= cfg_data[SIZE_W-1:0];
                CFG_TARGET_W: tgt_w_reg    <= cfg_data[SIZE_W-1:0];
                CFG_TARGET_H: tgt_h_reg    <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // palette and line memories, registered reads on accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (mode == MODE_PALETTE)
                palette_mem[index] <= {entry_alpha, entry_blue, entry_green, entry_red};
            pal_rd_reg  <= palette_mem[index];
            line_rd_reg <= line_mem[LINE_AW'(out_col_reg)];
        end
        if (line_wr)
            line_mem[wr_addr_reg] <= {div_rsp.quotient[2], div_rsp.quotient[1],
                                      div_rsp.quotient[0]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && mode == MODE_PIXEL)
                    state_next = ST_ACC;
            end
            ST_ACC:
                state_next = run_end ? ST_DIV : ST_IDLE;
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall        = (state_reg != ST_IDLE);
        div_req.start   = (state_reg == ST_ACC) && run_end;
        div_req.divisor = acc_cnt;
        emit_fire       = (state_reg == ST_EMIT) && slot_free;
        line_wr         = emit_fire && wr_ok_reg;
    end

    // accumulate and step decisions
    always_comb
    begin
        line_val = line_ok ? line_rd_reg : '0;
        use_line = (v_error_reg >= nh);
        if (sample_count_reg == '0)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                acc_sum[c] = SUM_W'(pal_rd_reg[c*CHAN_W +: CHAN_W])
                           + (use_line ? SUM_W'(line_val[c*CHAN_W +: CHAN_W]) : '0);
            acc_cnt   = use_line ? CNT_W'(2) : CNT_W'(1);
            acc_alpha = pal_rd_reg[4*CHAN_W-1:3*CHAN_W];
        end
        else
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                acc_sum[c] = sum_reg[c] + SUM_W'(pal_rd_reg[c*CHAN_W +: CHAN_W]);
            acc_cnt   = sample_count_reg + CNT_W'(1);
            acc_alpha = run_alpha_reg;
        end

        row_end  = ({1'b0, source_col_reg} + 10'd1) >= {1'b0, w};
        last_row = ({1'b0, source_row_reg} + 10'd1) >= {1'b0, h};
        h_sum    = {1'b0, h_error_reg} + {1'b0, nw};
        run_end  = row_end || (h_sum >= {1'b0, w});
        v_sum    = {1'b0, v_error_reg} + {1'b0, nh};

        // error stays at or below size minus one
        h_wrap = h_sum - {1'b0, w};
        if (h_wrap > {1'b0, w - SIZE_W'(1)})
            h_wrap = {1'b0, w - SIZE_W'(1)};
        v_wrap = v_sum - {1'b0, h};
        if (v_wrap > {1'b0, h - SIZE_W'(1)})
            v_wrap = {1'b0, h - SIZE_W'(1)};
    end

    // register next values
    always_comb
    begin
        sum_next          = sum_reg;
        sample_count_next = sample_count_reg;
        run_alpha_next    = run_alpha_reg;
        source_col_next   = source_col_reg;
        source_row_next   = source_row_reg;
        h_error_next      = h_error_reg;
        v_error_next      = v_error_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        pend_x_next       = pend_x_reg;
        pend_y_next       = pend_y_reg;
        pend_end_next     = pend_end_reg;
        wr_addr_next      = wr_addr_reg;
        wr_ok_next        = wr_ok_reg;
        out_valid_next    = out_valid_reg && out_stall;
        pix_x_next        = pix_x_reg;
        pix_y_next        = pix_y_reg;
        red_next          = red_reg;
        green_next        = green_reg;
        blue_next         = blue_reg;
        alpha_next        = alpha_reg;
        frame_end_next    = frame_end_reg;

        if (state_reg == ST_ACC)
        begin
            sum_next       = acc_sum;
            run_alpha_next = acc_alpha;
            if (!run_end)
            begin
                sample_count_next = acc_cnt;
                h_error_next      = SIZE_W'(h_sum);
                source_col_next   = source_col_reg + SIZE_W'(1);
            end
            else
            begin
                sample_count_next = '0;
                pend_x_next   = COORD_W'(origin_x_reg) + COORD_W'(out_col_reg);
                pend_y_next   = COORD_W'(origin_y_reg) + COORD_W'(out_row_reg);
                pend_end_next = row_end && last_row;
                wr_addr_next  = LINE_AW'(out_col_reg);
                wr_ok_next    = line_ok;
                out_col_next  = out_col_reg + SIZE_W'(1);
                if (!row_end)
                begin
                    h_error_next    = SIZE_W'(h_wrap);
                    source_col_next = source_col_reg + SIZE_W'(1);
                end
                else
                begin
                    h_error_next    = '0;
                    source_col_next = '0;
                    out_col_next    = '0;
                    if (last_row)
                    begin
                        source_row_next = '0;
                        v_error_next    = '0;
                        out_row_next    = '0;
                    end
                    else
                    begin
                        source_row_next = source_row_reg + SIZE_W'(1);
                        if (v_sum >= {1'b0, h})
                        begin
                            v_error_next = SIZE_W'(v_wrap);
                            out_row_next = out_row_reg + SIZE_W'(1);
                        end
                        else
                            v_error_next = SIZE_W'(v_sum);
                    end
                end
            end
        end

        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            pix_x_next     = pend_x_reg;
            pix_y_next     = pend_y_reg;
            red_next       = div_rsp.quotient[0];
            green_next     = div_rsp.quotient[1];
            blue_next      = div_rsp.quotient[2];
            alpha_next     = run_alpha_reg;
            frame_end_next = pend_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            sample_count_reg <= '0;
            run_alpha_reg    <= '0;
            source_col_reg   <= '0;
            source_row_reg   <= '0;
            h_error_reg      <= '0;
            v_error_reg      <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            sample_count_reg <= sample_count_next;
            run_alpha_reg    <= run_alpha_next;
            source_col_reg   <= source_col_next;
            source_row_reg   <= source_row_next;
            h_error_reg      <= h_error_next;
            v_error_reg      <= v_error_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        pend_end_reg  <= pend_end_next;
        wr_addr_reg   <= wr_addr_next;
        wr_ok_reg     <= wr_ok_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        alpha_reg     <= alpha_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha     = alpha_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: src/pbd_checker.sv
// Port-level checks for the palette box downscaler, bound to the top level.
// Depends on palette_box_downscaler_defines.svh.
`include "palette_box_downscaler_defines.svh"

module pbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [12:0] pix_x,
    input logic [12:0] pix_y,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [7:0]  alpha,
    input logic        frame_end
);

    // a waiting word stays put
    `PBD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output word dropped while stalled")
    `PBD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(pix_x) && $stable(pix_y) && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(frame_end), "output word changed while stalled")

    // an accepted pixel always leaves the sequencer busy, holding off input
    `PBD_ASSERT(a_pixel_busy, in_valid && !in_stall && mode |=> in_stall, "pixel word did not hold off input")

    // a fresh result only comes out of a busy sequencer
    `PBD_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(in_stall), "result without preceding work")

    `PBD_ASSERT_RST(a_reset_quiet, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind palette_box_downscaler pbd_checker u_pbd_checker (.*);
